[rtl/adn_pkg.sv]
// Package for ascii_date_next_day: character codes, field widths and calendar helpers.
package adn_pkg;

	localparam logic [7:0] XChar    = 8'h78;
	localparam logic [7:0] ZeroChar = 8'h30;
	localparam logic [7:0] NineChar = 8'h39;

	localparam int YearW  = 32;
	localparam int MonthW = 16;
	localparam int DayW   = 16;
	localparam int ClockW = 32;

	localparam int InW  = YearW + MonthW + DayW + 2 * ClockW;
	localparam int OutW = ((YearW + MonthW + DayW + 1 + 7) / 8) * 8;

	localparam logic [3:0] MonJan = 4'd1;
	localparam logic [3:0] MonFeb = 4'd2;
	localparam logic [3:0] MonApr = 4'd4;
	localparam logic [3:0] MonJun = 4'd6;
	localparam logic [3:0] MonSep = 4'd9;
	localparam logic [3:0] MonNov = 4'd11;
	localparam logic [3:0] MonDec = 4'd12;

	localparam logic [4:0] LenLeapFeb = 5'd29;
	localparam logic [4:0] LenFeb     = 5'd28;
	localparam logic [4:0] LenShort   = 5'd30;
	localparam logic [4:0] LenLong    = 5'd31;

	typedef logic [3:0][3:0] year_bcd_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= ZeroChar) && (c <= NineChar);
	endfunction

	// two BCD digits divisible by four
	function automatic logic div4(input logic [3:0] t, input logic [3:0] o);
		logic [1:0] s;
		s = {t[0], 1'b0} + o[1:0];
		return s == 2'd0;
	endfunction

	function automatic logic is_leap(input year_bcd_t y);
		logic cent;
		cent = (y[1] == 4'd0) && (y[0] == 4'd0);
		return (div4(y[1], y[0]) && !cent) || (cent && div4(y[3], y[2]));
	endfunction

	function automatic logic [4:0] month_len(input logic [6:0] m, input logic leap);
		logic [4:0] len;
		len = LenLong;
		if (m == {3'b000, MonFeb}) begin
			len = leap ? LenLeapFeb : LenFeb;
		end else if (m == {3'b000, MonApr} || m == {3'b000, MonJun} ||
				m == {3'b000, MonSep} || m == {3'b000, MonNov}) begin
			len = LenShort;
		end
		return len;
	endfunction

	// ASCII two-digit text of a value below 32
	function automatic logic [15:0] two_digits(input logic [4:0] v);
		logic [1:0] tens;
		logic [4:0] ones;
		if (v >= 5'd30) begin
			tens = 2'd3;
		end else if (v >= 5'd20) begin
			tens = 2'd2;
		end else if (v >= 5'd10) begin
			tens = 2'd1;
		end else begin
			tens = 2'd0;
		end
		ones = v - 5'({tens, 3'b000} + {2'b00, tens, 1'b0});
		return {ZeroChar | {6'd0, tens}, ZeroChar | {4'd0, ones[3:0]}};
	endfunction

endpackage

[rtl/ascii_date_next_day.sv]
// Top level of ascii_date_next_day: three-stage next-day date pipeline.
//
// channel   dir  data                                                   handshake
// s_axis    in   year 31:0, month 47:32, day 63:48, start 95:64,        tvalid/tready
//                arrive 127:96
// m_axis    out  next year 31:0, next month 47:32, next day 63:48,      tvalid/tready
//                was_advanced 64, zero 71:65
//
// One beat per cycle while the output is not stalled; stages: decode, calendar step, encode.
// arst_n clears the stage valid bits only.
// The stages move together; a stalled output holds every stage and tready drops.
module ascii_date_next_day (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// year_text, month_text, day_text, start_clock, arrive_clock
	input  logic [adn_pkg::InW-1:0]   s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// next_year_text, next_month_text, next_day_text, was_advanced, zero fill
	output logic [adn_pkg::OutW-1:0]  m_axis_tdata
);

	logic en;

	logic [31:0] year_in, start_in, arrive_in;
	logic [15:0] month_in, day_in;

	logic               valid_s1, adv_s1, xmark_s1, ok_s1;
	adn_pkg::year_bcd_t yd_s1;
	logic [6:0]         month_s1, day_s1;
	logic [31:0]        ytext_s1;
	logic [15:0]        mtext_s1, dtext_s1;

	logic               valid_s2, adv_s2, use_new_s2, use_x_s2, yinc_s2;
	adn_pkg::year_bcd_t yd_s2;
	logic [3:0]         nmonth_s2;
	logic [4:0]         nday_s2;
	logic [31:0]        ytext_s2;
	logic [15:0]        mtext_s2, dtext_s2;

	logic                    valid_s3;
	logic [adn_pkg::OutW-1:0] data_s3;

	logic       leap, mvalid, day_in_month;
	logic [4:0] mlen;

	adn_pkg::year_bcd_t yinc_bcd;
	logic [31:0]        year_new;
	logic [31:0]        year_out;
	logic [15:0]        month_out, day_out;

	assign year_in   = s_axis_tdata[31:0];
	assign month_in  = s_axis_tdata[47:32];
	assign day_in    = s_axis_tdata[63:48];
	assign start_in  = s_axis_tdata[95:64];
	assign arrive_in = s_axis_tdata[127:96];

	assign en            = !valid_s3 || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = data_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: compare times, check and decode digits
	always_ff @(posedge clk) begin
		if (en) begin
			adv_s1   <= start_in < arrive_in;
			xmark_s1 <= year_in[31:24] == adn_pkg::XChar;
			ok_s1    <= adn_pkg::is_digit(year_in[31:24]) && adn_pkg::is_digit(year_in[23:16]) &&
				adn_pkg::is_digit(year_in[15:8]) && adn_pkg::is_digit(year_in[7:0]) &&
				adn_pkg::is_digit(month_in[15:8]) && adn_pkg::is_digit(month_in[7:0]) &&
				adn_pkg::is_digit(day_in[15:8]) && adn_pkg::is_digit(day_in[7:0]);
			yd_s1    <= {year_in[27:24], year_in[19:16], year_in[11:8], year_in[3:0]};
			month_s1 <= {month_in[11:8], 3'b000} + {2'b00, month_in[11:8], 1'b0} +
				{3'b000, month_in[3:0]};
			day_s1   <= {day_in[11:8], 3'b000} + {2'b00, day_in[11:8], 1'b0} +
				{3'b000, day_in[3:0]};
			ytext_s1 <= year_in;
			mtext_s1 <= month_in;
			dtext_s1 <= day_in;
		end
	end

	// stage 2: calendar step
	always_comb begin
		leap         = adn_pkg::is_leap(yd_s1);
		mlen         = adn_pkg::month_len(month_s1, leap);
		mvalid       = (month_s1 >= 7'd1) && (month_s1 <= {3'b000, adn_pkg::MonDec});
		day_in_month = day_s1 < {2'b00, mlen};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adv_s2     <= adv_s1;
			use_x_s2   <= adv_s1 && xmark_s1;
			use_new_s2 <= adv_s1 && !xmark_s1 && ok_s1 && mvalid;
			yd_s2      <= yd_s1;
			ytext_s2   <= ytext_s1;
			mtext_s2   <= mtext_s1;
			dtext_s2   <= dtext_s1;
			if (day_in_month) begin
				nday_s2   <= day_s1[4:0] + 5'd1;
				nmonth_s2 <= month_s1[3:0];
				yinc_s2   <= 1'b0;
			end else begin
				nday_s2 <= 5'd1;
				if (month_s1 == {3'b000, adn_pkg::MonDec}) begin
					nmonth_s2 <= adn_pkg::MonJan;
					yinc_s2   <= 1'b1;
				end else begin
					nmonth_s2 <= month_s1[3:0] + 4'd1;
					yinc_s2   <= 1'b0;
				end
			end
		end
	end

	// stage 3: BCD year increment, encode, select
	always_comb begin
		logic c;
		c = yinc_s2;
		for (int i = 0; i < 4; i++) begin
			if (c && yd_s2[i] == 4'd9) begin
				yinc_bcd[i] = 4'd0;
			end else if (c) begin
				yinc_bcd[i] = yd_s2[i] + 4'd1;
				c = 1'b0;
			end else begin
				yinc_bcd[i] = yd_s2[i];
			end
		end
		for (int i = 0; i < 4; i++) begin
			year_new[8*i +: 8] = adn_pkg::ZeroChar | {4'd0, yinc_bcd[i]};
		end
		if (use_x_s2) begin
			year_out  = {4{adn_pkg::XChar}};
			month_out = {2{adn_pkg::XChar}};
			day_out   = {2{adn_pkg::XChar}};
		end else if (use_new_s2) begin
			year_out  = year_new;
			month_out = adn_pkg::two_digits({1'b0, nmonth_s2});
			day_out   = adn_pkg::two_digits(nday_s2);
		end else begin
			year_out  = ytext_s2;
			month_out = mtext_s2;
			day_out   = dtext_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s3 <= {(adn_pkg::OutW - 65)'(0), adv_s2, day_out, month_out, year_out};
		end
	end

endmodule

[dv/tb_ascii_date_next_day.sv]
// Testbench for ascii_date_next_day: directed and random dates against a next-day predictor.
`timescale 1ns / 100ps

module tb_ascii_date_next_day;

	localparam int IdlePct    = 27;
	localparam int StallLimit = 1000;
	localparam int MaxReports = 10;

	typedef struct packed {
		logic [31:0] year_txt;
		logic [15:0] month_txt;
		logic [15:0] day_txt;
		logic [31:0] start_hm;
		logic [31:0] arrive_hm;
	} date_req_t;

	typedef struct packed {
		logic [6:0]  fill;
		logic        advanced;
		logic [15:0] day;
		logic [15:0] month;
		logic [31:0] year;
	} date_res_t;

	logic                     clk;
	logic                     arst_n;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	// year_text, month_text, day_text, start_clock, arrive_clock
	logic [adn_pkg::InW-1:0]  s_axis_tdata;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	// next_year_text, next_month_text, next_day_text, was_advanced, zero fill
	logic [adn_pkg::OutW-1:0] m_axis_tdata;

	date_res_t   expected_dates[$];
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	bit          steady;

	ascii_date_next_day dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// low four bytes hold the ASCII decimal digits of v, least significant in bits 7:0
	function automatic logic [31:0] ascii_num(input int unsigned v);
		logic [31:0] txt;
		int i;
		for (i = 0; i < 4; i++) begin
			txt[8*i +: 8] = 8'(adn_pkg::ZeroChar + v % 10);
			v = v / 10;
		end
		return txt;
	endfunction

	function automatic date_res_t next_day_of(input date_req_t r);
		date_res_t   res;
		logic [63:0] txt;
		logic        digits_ok;
		logic        leap;
		int          i;
		int unsigned yr, mo, dy, mlen;
		res = '{year: r.year_txt, month: r.month_txt, day: r.day_txt,
			advanced: r.start_hm < r.arrive_hm, fill: '0};
		if (!res.advanced)
			return res;
		if (r.year_txt[31:24] == adn_pkg::XChar) begin
			res.year  = {4{adn_pkg::XChar}};
			res.month = {2{adn_pkg::XChar}};
			res.day   = {2{adn_pkg::XChar}};
			return res;
		end
		txt = {r.year_txt, r.month_txt, r.day_txt};
		digits_ok = 1'b1;
		for (i = 0; i < 8; i++) begin
			if (txt[8*i +: 8] < adn_pkg::ZeroChar || txt[8*i +: 8] > adn_pkg::NineChar)
				digits_ok = 1'b0;
		end
		if (!digits_ok)
			return res;
		yr = 0;
		for (i = 3; i >= 0; i--)
			yr = yr * 10 + (r.year_txt[8*i +: 8] - adn_pkg::ZeroChar);
		mo = (r.month_txt[15:8] - adn_pkg::ZeroChar) * 10 +
			(r.month_txt[7:0] - adn_pkg::ZeroChar);
		dy = (r.day_txt[15:8] - adn_pkg::ZeroChar) * 10 +
			(r.day_txt[7:0] - adn_pkg::ZeroChar);
		if (mo < adn_pkg::MonJan || mo > adn_pkg::MonDec)
			return res;
		leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
		if (mo == adn_pkg::MonFeb) begin
			mlen = leap ? adn_pkg::LenLeapFeb : adn_pkg::LenFeb;
		end else if (mo == adn_pkg::MonApr || mo == adn_pkg::MonJun ||
				mo == adn_pkg::MonSep || mo == adn_pkg::MonNov) begin
			mlen = adn_pkg::LenShort;
		end else begin
			mlen = adn_pkg::LenLong;
		end
		if (dy < mlen) begin
			dy++;
		end else begin
			dy = 1;
			if (mo == adn_pkg::MonDec) begin
				mo = adn_pkg::MonJan;
				yr = (yr + 1) % 10000;
			end else begin
				mo++;
			end
		end
		res.year  = ascii_num(yr);
		res.month = 16'(ascii_num(mo));
		res.day   = 16'(ascii_num(dy));
		return res;
	endfunction

	// entered and left at a falling edge
	task automatic send_date(input date_req_t r);
		while (!steady && $urandom_range(99) < IdlePct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata  <= {r.arrive_hm, r.start_hm, r.day_txt, r.month_txt, r.year_txt};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_dates.push_back(next_day_of(r));
		@(negedge clk);
	endtask

	task automatic send_text(input logic [31:0] y, input logic [15:0] m, input logic [15:0] d,
			input logic [31:0] st, input logic [31:0] ar);
		date_req_t r;
		r = '{year_txt: y, month_txt: m, day_txt: d, start_hm: st, arrive_hm: ar};
		send_date(r);
	endtask

	task automatic wait_all_results();
		s_axis_tvalid <= 1'b0;
		while (expected_dates.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_calendar_edges();
		send_text("2024", "02", "28", "0800", "0930");
		send_text("2024", "02", "29", "0800", "0930");
		send_text("2023", "02", "28", "0800", "0930");
		send_text("1900", "02", "28", "0800", "0930");
		send_text("2000", "02", "28", "0800", "0930");
		send_text("0000", "02", "28", "0800", "0930");
		send_text("2023", "04", "30", "0800", "0930");
		send_text("2023", "01", "31", "0800", "0930");
		send_text("2023", "12", "31", "0800", "0930");
		send_text("9999", "12", "31", "0800", "0930");
		send_text("2023", "06", "15", "0800", "0930");
	endtask

	task automatic test_clock_compare();
		send_text("2023", "12", "31", "1200", "1200");
		send_text("2023", "12", "31", "2359", "0000");
		send_text("2023", "12", "31", "0000", "0001");
	endtask

	task automatic test_special_cases();
		send_text("x023", "05", "10", "0800", "0930");
		send_text("x023", "05", "10", "0930", "0800");
		send_text("2023", "05", "1a", "0800", "0930");
		send_text("2023", "00", "10", "0800", "0930");
		send_text("2023", "13", "10", "0800", "0930");
		send_text("2023", "99", "10", "0800", "0930");
		send_text("2023", "03", "00", "0800", "0930");
		send_text("2023", "12", "99", "0800", "0930");
		send_text('1, '1, '1, '0, '1);
		send_text('0, '0, '0, '0, 32'd1);
		send_text('1, '1, '1, '1, '1);
	endtask

	task automatic test_random_dates(input int count);
		date_req_t   r;
		logic [63:0] txt;
		int unsigned kind, yr, mo, dy, pos;
		int          k;
		for (k = 0; k < count; k++) begin
			kind = $urandom_range(99);
			if (kind < 8) begin
				r = '{year_txt: $urandom, month_txt: 16'($urandom), day_txt: 16'($urandom),
					start_hm: $urandom, arrive_hm: $urandom};
			end else begin
				case ($urandom_range(5))
					0: yr = 0;
					1: yr = 9999;
					2: yr = $urandom_range(99) * 100;
					default: yr = $urandom_range(9999);
				endcase
				mo = (kind < 16) ? $urandom_range(99) : $urandom_range(1, 12);
				dy = ($urandom_range(3) == 0) ? $urandom_range(99) : $urandom_range(27, 31);
				r.year_txt  = ascii_num(yr);
				r.month_txt = 16'(ascii_num(mo));
				r.day_txt   = 16'(ascii_num(dy));
				if (kind < 22) begin
					txt = {r.year_txt, r.month_txt, r.day_txt};
					pos = $urandom_range(7);
					txt[8*pos +: 8] = 8'($urandom_range(255));
					{r.year_txt, r.month_txt, r.day_txt} = txt;
				end else if (kind < 28) begin
					r.year_txt[31:24] = adn_pkg::XChar;
				end
				r.start_hm = ascii_num($urandom_range(23) * 100 + $urandom_range(59));
				if ($urandom_range(9) == 0)
					r.arrive_hm = r.start_hm;
				else
					r.arrive_hm = ascii_num($urandom_range(23) * 100 + $urandom_range(59));
			end
			send_date(r);
		end
	endtask

	task automatic test_back_to_back(input int count);
		steady = 1'b1;
		test_random_dates(count);
		steady = 1'b0;
	endtask

	always @(negedge clk)
		m_axis_tready <= steady || ($urandom_range(99) >= IdlePct);

	always @(posedge clk) begin : check_results
		date_res_t want;
		date_res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = date_res_t'(m_axis_tdata);
			if (expected_dates.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReports)
					$display("unexpected result beat %h", m_axis_tdata);
			end else begin
				want = expected_dates.pop_front();
				if (got.year !== want.year || got.month !== want.month ||
						got.day !== want.day || got.advanced !== want.advanced ||
						got.fill !== want.fill) begin
					mismatches++;
					if (mismatches <= MaxReports)
						$display("mismatch: expected %h %h %h adv %b fill %h, %s",
							want.year, want.month, want.day, want.advanced, want.fill,
							$sformatf("got %h %h %h adv %b fill %h",
							got.year, got.month, got.day, got.advanced, got.fill));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= StallLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		steady        = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_calendar_edges();
		test_clock_compare();
		test_special_cases();
		test_random_dates(200);
		wait_all_results();
		test_back_to_back(100);
		test_random_dates(200);

		wait_all_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
